@@ sv/gdds_pkg.sv @@
// ============================================================================
// gdds_pkg
// Shared constants, payload types and control/status types for the diffusion
// grid block.
// ============================================================================
`default_nettype none

package gdds_pkg;

    localparam int GRID_SIZE   = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int CELLS       = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int ROW_W       = $clog2(GRID_SIZE);
    localparam int CNT_W       = $clog2(CELLS + GRID_SIZE);
    localparam int FRAC_W      = 16;
    localparam int SUM_W       = 44;
    localparam int SQ_W        = 64;
    localparam int OUT_W       = 32;
    localparam int FIELD_W     = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int DIFF_W      = 15;
    localparam int DECAY_W     = 16;
    localparam int SCALE_W     = 4;
    localparam int K_W         = DECAY_W + SCALE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRODUCE   = 3'd4;

    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_PROD  = 3'd2;
    localparam logic [2:0] CMD_STEP  = 3'd3;
    localparam logic [2:0] CMD_STATS = 3'd4;

    typedef struct packed {
        logic [2:0]         command;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic [31:0]        write_value;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] read_value;
        logic [SUM_W-1:0] total_loss;
        logic [SUM_W-1:0] grid_sum;
        logic [SQ_W-1:0]  grid_sum_squares;
        logic [OUT_W-1:0] min_value;
        logic [OUT_W-1:0] max_value;
    } out_item_t;

    typedef enum logic [1:0] {
        SWEEP_CLEAR,
        SWEEP_STEP,
        SWEEP_STATS
    } sweep_kind_t;

    typedef struct packed {
        logic        load_item;
        logic        sweep_start;
        sweep_kind_t sweep_kind;
        logic        cell_rd;
        logic        cell_wr;
        logic        prod_wr;
        logic        out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       busy;
        logic       addr_ok;
        logic [2:0] command;
    } dp_status_t;

endpackage

`default_nettype wire

@@ sv/gdds_ram.sv @@
// ============================================================================
// gdds_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
`default_nettype none

module gdds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/gdds_ctrl.sv @@
// ============================================================================
// gdds_ctrl
// Command sequencer: accepts one item, steps the datapath through it, and
// hands the result to the output register.
// ============================================================================
`default_nettype none

module gdds_ctrl
    import gdds_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_CLR,
        S_CLRW,
        S_IDLE,
        S_DISP,
        S_WR,
        S_PRD,
        S_PWR,
        S_SWEEP,
        S_WAIT,
        S_RB,
        S_CAP
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sweep_kind = SWEEP_CLEAR;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.sweep_start = 1'b1;
                state_next      = S_CLRW;
            end
            S_CLRW:
            begin
                if (!status.busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                case (status.command) inside
                    CMD_WRITE:           state_next = status.addr_ok ? S_WR : S_RB;
                    CMD_PROD:            state_next = status.addr_ok ? S_PRD : S_RB;
                    CMD_STEP, CMD_STATS: state_next = S_SWEEP;
                    default:             state_next = S_RB;
                endcase
            end
            S_WR:
            begin
                cmd.cell_wr = 1'b1;
                state_next  = S_RB;
            end
            S_PRD:
            begin
                cmd.cell_rd = 1'b1;
                state_next  = S_PWR;
            end
            S_PWR:
            begin
                cmd.prod_wr = 1'b1;
                state_next  = S_RB;
            end
            S_SWEEP:
            begin
                cmd.sweep_start = 1'b1;
                cmd.sweep_kind  = (status.command == CMD_STEP) ? SWEEP_STEP : SWEEP_STATS;
                state_next      = S_WAIT;
            end
            S_WAIT:
            begin
                if (!status.busy)
                begin
                    state_next = S_RB;
                end
            end
            S_RB:
            begin
                cmd.cell_rd = 1'b1;
                state_next  = S_CAP;
            end
            S_CAP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = cmd.out_load | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // new items only once the grid is quiet
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !status.busy)
        else $error("item accepted while datapath busy");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output overwritten");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

@@ sv/gdds_datapath.sv @@
// ============================================================================
// gdds_datapath
// Grid memory, cell sweep counter, 5-point stencil pipeline with line
// buffer, statistics accumulators, configuration and output registers.
// ============================================================================
`default_nettype none

module gdds_datapath
    import gdds_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire in_item_t              in_data,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    output out_item_t                  out_data
);

    localparam int VW       = VALUE_WIDTH;
    localparam int LAP_W    = VW + 2;
    localparam int P1_W     = LAP_W + DIFF_W;
    localparam int CHG_W    = P1_W - FRAC_W;
    localparam int P2_W     = VW + K_W;
    localparam int LOSS_W   = P2_W - FRAC_W;
    localparam int TAPS     = 2 * GRID_SIZE + 1;
    localparam int CTR      = GRID_SIZE / 2;
    localparam int LIM      = (CTR * CTR) / 4;
    localparam int DI_W     = ROW_W + 2;
    localparam int DSQ_W    = 2 * DI_W + 1;
    localparam logic [VW-1:0]    CELL_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX  = '1;
    localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CELLS + GRID_SIZE - 1);
    localparam logic [ROW_W-1:0] EDGE      = ROW_W'(GRID_SIZE - 1);

    // configuration
    logic [DIFF_W-1:0]  diff_reg;
    logic [DECAY_W-1:0] decay_reg;
    logic               mode_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [VW-1:0]      prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg  <= DIFF_W'(4096);
            decay_reg <= DECAY_W'(655);
            mode_reg  <= 1'b0;
            scale_reg <= SCALE_W'(5);
            prod_reg  <= VW'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIFFUSION: diff_reg  <= cfg_data[DIFF_W-1:0];
                CFG_DECAY:     decay_reg <= cfg_data[DECAY_W-1:0];
                CFG_MODE:      mode_reg  <= cfg_data[0];
                CFG_SCALE:     scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_PRODUCE:   prod_reg  <= VW'(cfg_data);
                default:       ;
            endcase
        end
    end

    // held item
    in_item_t          item_reg;
    logic              addr_ok;
    logic [ADDR_W-1:0] item_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
    end

    assign addr_ok   = (32'(item_reg.row) < 32'(GRID_SIZE)) &&
                       (32'(item_reg.col) < 32'(GRID_SIZE));
    assign item_addr = ADDR_W'(ADDR_W'(item_reg.row) * ADDR_W'(GRID_SIZE)
                       + ADDR_W'(item_reg.col));

    // sweep counter
    logic              active_reg;
    sweep_kind_t       kind_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              sweep_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            kind_reg   <= SWEEP_CLEAR;
            cnt_reg    <= '0;
        end
        else if (cmd.sweep_start)
        begin
            active_reg <= 1'b1;
            kind_reg   <= cmd.sweep_kind;
            cnt_reg    <= '0;
        end
        else if (active_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == ((kind_reg == SWEEP_STEP) ? LAST_STEP : LAST_CELL))
            begin
                active_reg <= 1'b0;
            end
        end
    end

    assign sweep_rd = active_reg && (kind_reg != SWEEP_CLEAR) && (cnt_reg <= LAST_CELL);

    // grid memory ports
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0]     ram_wdata, ram_rdata;
    logic [VW:0]       prod_sum;
    logic              s5_we;
    logic [ADDR_W-1:0] s5_addr;
    logic [VW-1:0]     s5_val;

    assign prod_sum  = {1'b0, ram_rdata} + {1'b0, prod_reg};
    assign ram_re    = sweep_rd | cmd.cell_rd;
    assign ram_raddr = active_reg ? cnt_reg[ADDR_W-1:0] : item_addr;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = item_addr;
        ram_wdata = item_reg.write_value[VW-1:0];
        if (active_reg && kind_reg == SWEEP_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg[ADDR_W-1:0];
            ram_wdata = '0;
        end
        else if (s5_we)
        begin
            ram_we    = 1'b1;
            ram_waddr = s5_addr;
            ram_wdata = s5_val;
        end
        else if (cmd.cell_wr)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.prod_wr)
        begin
            ram_we    = 1'b1;
            ram_wdata = prod_sum[VW] ? CELL_MAX : prod_sum[VW-1:0];
        end
    end

    gdds_ram #(.WIDTH(VW), .DEPTH(CELLS)) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // line buffer: tap 0 newest (row below), tap G centre, tap 2G row above
    logic [VW-1:0]    tap_reg [0:TAPS-1];
    logic             shift_v_reg, win_v_reg, st_v_reg;
    logic [CNT_W-1:0] shift_idx_reg, win_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_v_reg <= 1'b0;
            win_v_reg   <= 1'b0;
            st_v_reg    <= 1'b0;
        end
        else
        begin
            shift_v_reg <= active_reg && (kind_reg == SWEEP_STEP);
            win_v_reg   <= shift_v_reg;
            st_v_reg    <= active_reg && (kind_reg == SWEEP_STATS);
        end
    end

    always_ff @(posedge clk)
    begin
        shift_idx_reg <= cnt_reg;
        if (shift_v_reg)
        begin
            win_idx_reg <= shift_idx_reg;
            tap_reg[0]  <= ram_rdata;
            for (int t = 1; t < TAPS; t++)
            begin
                tap_reg[t] <= tap_reg[t-1];
            end
        end
    end

    // stage 1: Laplacian magnitude and circle test
    logic              s1_fire;
    logic [ROW_W-1:0]  ci_reg, cj_reg;
    logic [ADDR_W-1:0] pa_reg;
    logic [VW-1:0]     h, nl, nr, nu, nd;
    logic [LAP_W-1:0]  pos, neg;
    logic signed [DI_W-1:0] di, dj;
    logic signed [DSQ_W-1:0] di_x, dj_x;
    logic [DSQ_W-1:0]  dsq;

    assign s1_fire = win_v_reg && (win_idx_reg >= CNT_W'(GRID_SIZE));
    assign h   = tap_reg[GRID_SIZE];
    assign nl  = (ci_reg == '0)  ? h : tap_reg[2*GRID_SIZE];
    assign nr  = (ci_reg == EDGE) ? h : tap_reg[0];
    assign nu  = (cj_reg == '0)  ? h : tap_reg[GRID_SIZE+1];
    assign nd  = (cj_reg == EDGE) ? h : tap_reg[GRID_SIZE-1];
    assign pos = LAP_W'(nl) + LAP_W'(nr) + LAP_W'(nu) + LAP_W'(nd);
    assign neg = {h, 2'b00};
    assign di  = $signed({2'b00, ci_reg}) - DI_W'(CTR);
    assign dj  = $signed({2'b00, cj_reg}) - DI_W'(CTR);
    // squares need the full product width
    assign di_x = DSQ_W'(di);
    assign dj_x = DSQ_W'(dj);
    assign dsq = DSQ_W'($unsigned(di_x * di_x)) + DSQ_W'($unsigned(dj_x * dj_x));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ci_reg <= '0;
            cj_reg <= '0;
            pa_reg <= '0;
        end
        else if (cmd.sweep_start)
        begin
            ci_reg <= '0;
            cj_reg <= '0;
            pa_reg <= '0;
        end
        else if (s1_fire)
        begin
            pa_reg <= pa_reg + ADDR_W'(1);
            if (cj_reg == EDGE)
            begin
                cj_reg <= '0;
                ci_reg <= ci_reg + ROW_W'(1);
            end
            else
            begin
                cj_reg <= cj_reg + ROW_W'(1);
            end
        end
    end

    logic              s1_v, s2_v, s3_v, s4_v;
    logic [VW-1:0]     s1_h, s2_h;
    logic              s1_ge, s2_ge, s1_in;
    logic [LAP_W-1:0]  s1_mag;
    logic [ADDR_W-1:0] s1_a, s2_a, s3_a, s4_a;
    logic [P1_W-1:0]   s2_p;
    logic [K_W-1:0]    s2_k, s3_k;
    logic [VW-1:0]     s3_n, s4_n;
    logic [P2_W-1:0]   s4_p;
    logic [CHG_W-1:0]  chg;
    logic [VW+1:0]     up;
    logic [VW-1:0]     n_new;
    logic [LOSS_W-1:0] loss;
    logic [SUM_W:0]    tot_sum;
    logic [SUM_W-1:0]  total_reg;

    assign chg   = s2_p[P1_W-1:FRAC_W];
    assign up    = (VW+2)'(s2_h) + (VW+2)'(chg);
    assign n_new = s2_ge ? ((up > (VW+2)'(CELL_MAX)) ? CELL_MAX : up[VW-1:0])
                         : (((VW+2)'(s2_h) > (VW+2)'(chg)) ? VW'(s2_h - VW'(chg)) : '0);
    assign loss  = s4_p[P2_W-1:FRAC_W];
    assign s5_we   = s4_v;
    assign s5_addr = s4_a;
    assign s5_val  = (loss > LOSS_W'(s4_n)) ? '0 : VW'(s4_n - VW'(loss));
    assign tot_sum = (SUM_W+1)'(total_reg) + (SUM_W+1)'(loss);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v <= 1'b0;
            s2_v <= 1'b0;
            s3_v <= 1'b0;
            s4_v <= 1'b0;
        end
        else
        begin
            s1_v <= s1_fire;
            s2_v <= s1_v;
            s3_v <= s2_v;
            s4_v <= s3_v;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_h   <= h;
        s1_ge  <= (pos >= neg);
        s1_mag <= (pos >= neg) ? pos - neg : neg - pos;
        s1_in  <= (dsq < DSQ_W'(LIM));
        s1_a   <= pa_reg;

        s2_p  <= P1_W'(s1_mag) * P1_W'(diff_reg);
        s2_h  <= s1_h;
        s2_ge <= s1_ge;
        s2_a  <= s1_a;
        if (!mode_reg)
        begin
            s2_k <= K_W'(decay_reg);
        end
        else
        begin
            s2_k <= s1_in ? K_W'(decay_reg) * K_W'(scale_reg) : '0;
        end

        s3_n <= n_new;
        s3_k <= s2_k;
        s3_a <= s2_a;

        s4_p <= P2_W'(s3_n) * P2_W'(s3_k);
        s4_n <= s3_n;
        s4_a <= s3_a;
    end

    // loss is only counted when the cell stays non-negative
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_start)
        begin
            total_reg <= '0;
        end
        else if (s4_v && (loss <= LOSS_W'(s4_n)))
        begin
            total_reg <= tot_sum[SUM_W] ? SUM_MAX : tot_sum[SUM_W-1:0];
        end
    end

    // statistics
    logic [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]  sq_reg, sqp_reg;
    logic             sqv_reg;
    logic [VW-1:0]    mn_reg, mx_reg;
    logic [SUM_W:0]   st_sum;
    logic [SQ_W:0]    st_sq;

    assign st_sum = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(ram_rdata);
    assign st_sq  = (SQ_W+1)'(sq_reg) + (SQ_W+1)'(sqp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqv_reg <= 1'b0;
        end
        else
        begin
            sqv_reg <= st_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sqp_reg <= SQ_W'(ram_rdata) * SQ_W'(ram_rdata);
        if (cmd.sweep_start)
        begin
            sum_reg <= '0;
            sq_reg  <= '0;
            mn_reg  <= '1;
            mx_reg  <= '0;
        end
        else
        begin
            if (st_v_reg)
            begin
                sum_reg <= st_sum[SUM_W] ? SUM_MAX : st_sum[SUM_W-1:0];
                if (ram_rdata < mn_reg)
                begin
                    mn_reg <= ram_rdata;
                end
                if (ram_rdata > mx_reg)
                begin
                    mx_reg <= ram_rdata;
                end
            end
            if (sqv_reg)
            begin
                sq_reg <= st_sq[SQ_W] ? '1 : st_sq[SQ_W-1:0];
            end
        end
    end

    // output register
    out_item_t out_reg;
    logic      is_stats;

    assign is_stats = (item_reg.command == CMD_STATS);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.read_value       <= addr_ok ? OUT_W'(ram_rdata) : '0;
            out_reg.total_loss       <= (item_reg.command == CMD_STEP) ? total_reg : '0;
            out_reg.grid_sum         <= is_stats ? sum_reg : '0;
            out_reg.grid_sum_squares <= is_stats ? sq_reg : '0;
            out_reg.min_value        <= is_stats ? OUT_W'(mn_reg) : '0;
            out_reg.max_value        <= is_stats ? OUT_W'(mx_reg) : '0;
        end
    end

    assign out_data       = out_reg;
    assign status.busy    = active_reg | shift_v_reg | win_v_reg | s1_v | s2_v | s3_v | s4_v
                            | st_v_reg | sqv_reg;
    assign status.addr_ok = addr_ok;
    assign status.command = item_reg.command;

    // stencil write-back must trail the sweep read by at least a row
    a_wb_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (s5_we && active_reg) |-> (32'(cnt_reg) > 32'(s5_addr) + GRID_SIZE))
        else $error("write-back overtook line buffer read");

    a_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        s5_we |-> !(cmd.cell_wr || cmd.prod_wr))
        else $error("single-cell write during step");

endmodule

`default_nettype wire

@@ sv/grid_diffusion_decay_stencil.sv @@
// ============================================================================
// grid_diffusion_decay_stencil
// 64x64 Q24.8 diffusion grid with decay, production and statistics.
// ============================================================================
// One command is in flight at a time; a finished result sits in the output
// register while the next command is taken. A diffusion step sweeps the grid
// through the single read port of the grid RAM, one cell per cycle, running
// one row of line-buffer lead past the last cell, and then drains the stencil
// pipeline. After reset a clearing pass zeroes the grid before the first
// input transfer; configuration writes are taken throughout.
`default_nettype none

module grid_diffusion_decay_stencil
    import gdds_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    gdds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    gdds_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ tb/grid_diffusion_decay_stencil_tb.sv @@
// ----------------------------------------------------------------------------
// grid_diffusion_decay_stencil_tb
// Drives grid commands and register writes into the diffusion grid, predicts
// every result with a bit-accurate software model of the grid, and checks each
// output transfer field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_diffusion_decay_stencil_tb;
    import gdds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned LOSS_CAP = (64'd1 << SUM_W) - 1;
    localparam longint unsigned CELL_TOP = (64'd1 << VALUE_WIDTH) - 1;
    localparam int STALL_LIMIT = 40000;

    // Grid model plus queue of pending results.
    class grid_scoreboard;
        longint unsigned cells[CELLS];
        longint unsigned diff_c, decay_c, mode_c, scale_c, prod_c;
        out_item_t pending[$];
        int errors;
        int checked;

        function new();
            foreach (cells[i]) cells[i] = 0;
            diff_c = 4096;
            decay_c = 655;
            mode_c = 0;
            scale_c = 5;
            prod_c = 256;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DIFFUSION: diff_c = 64'(val[DIFF_W-1:0]);
                CFG_DECAY:     decay_c = 64'(val[DECAY_W-1:0]);
                CFG_MODE:      mode_c = 64'(val[0]);
                CFG_SCALE:     scale_c = 64'(val[SCALE_W-1:0]);
                CFG_PRODUCE:   prod_c = 64'(val);
                default: ;
            endcase
        endfunction

        function longint unsigned frac_mul(longint unsigned v, longint unsigned c);
            return (v >> 16) * c + (((v & 64'hFFFF) * c) >> 16);
        endfunction

        function longint unsigned diffuse_once();
            longint unsigned old[CELLS];
            longint unsigned h, l, r, u, d, pos, neg, n, k, loss, total;
            int ctr, rad, di, dj;
            old = cells;
            total = 0;
            ctr = GRID_SIZE / 2;
            rad = (ctr * ctr) / 4;
            for (int i = 0; i < GRID_SIZE; i++)
                for (int j = 0; j < GRID_SIZE; j++)
                begin
                    h = old[i*GRID_SIZE+j];
                    l = (i == 0) ? h : old[(i-1)*GRID_SIZE+j];
                    r = (i == GRID_SIZE-1) ? h : old[(i+1)*GRID_SIZE+j];
                    u = (j == 0) ? h : old[i*GRID_SIZE+j-1];
                    d = (j == GRID_SIZE-1) ? h : old[i*GRID_SIZE+j+1];
                    pos = l + r + u + d;
                    neg = 4 * h;
                    if (pos >= neg)
                    begin
                        n = h + frac_mul(pos - neg, diff_c);
                        if (n > CELL_TOP) n = CELL_TOP;
                    end
                    else
                    begin
                        k = frac_mul(neg - pos, diff_c);
                        n = (h > k) ? h - k : 0;
                    end
                    di = i - ctr;
                    dj = j - ctr;
                    if (mode_c == 0) k = decay_c;
                    else if (di*di + dj*dj < rad) k = decay_c * scale_c;
                    else k = 0;
                    loss = frac_mul(n, k);
                    if (loss > n) n = 0;
                    else
                    begin
                        n -= loss;
                        total += loss;
                        if (total > LOSS_CAP) total = LOSS_CAP;
                    end
                    cells[i*GRID_SIZE+j] = n;
                end
            return total;
        endfunction

        function void note_command(in_item_t it);
            out_item_t res;
            int a;
            longint unsigned v, sum, sq, lo, hi, s;
            res = '0;
            a = it.row * GRID_SIZE + it.col;
            case (it.command)
                CMD_WRITE: cells[a] = 64'(it.write_value);
                CMD_PROD:
                begin
                    v = cells[a] + prod_c;
                    cells[a] = (v > CELL_TOP) ? CELL_TOP : v;
                end
                CMD_STEP: res.total_loss = SUM_W'(diffuse_once());
                CMD_STATS:
                begin
                    sum = 0; sq = 0; lo = cells[0]; hi = cells[0];
                    foreach (cells[n])
                    begin
                        v = cells[n];
                        sum += v;
                        if (sum > LOSS_CAP) sum = LOSS_CAP;
                        s = v * v;
                        sq = (sq > 64'hFFFF_FFFF_FFFF_FFFF - s) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                              : sq + s;
                        if (v < lo) lo = v;
                        if (v > hi) hi = v;
                    end
                    res.grid_sum = SUM_W'(sum);
                    res.grid_sum_squares = sq;
                    res.min_value = OUT_W'(lo);
                    res.max_value = OUT_W'(hi);
                end
                default: ;
            endcase
            res.read_value = OUT_W'(cells[a]);
            pending.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                $error("result with nothing pending: %p", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.read_value !== want.read_value)
            begin
                $error("read_value exp %h got %h", want.read_value, got.read_value);
                errors++;
            end
            if (got.total_loss !== want.total_loss)
            begin
                $error("total_loss exp %h got %h", want.total_loss, got.total_loss);
                errors++;
            end
            if (got.grid_sum !== want.grid_sum)
            begin
                $error("grid_sum exp %h got %h", want.grid_sum, got.grid_sum);
                errors++;
            end
            if (got.grid_sum_squares !== want.grid_sum_squares)
            begin
                $error("grid_sum_squares exp %h got %h", want.grid_sum_squares,
                       got.grid_sum_squares);
                errors++;
            end
            if (got.min_value !== want.min_value)
            begin
                $error("min_value exp %h got %h", want.min_value, got.min_value);
                errors++;
            end
            if (got.max_value !== want.max_value)
            begin
                $error("max_value exp %h got %h", want.max_value, got.max_value);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    grid_scoreboard grid_sb;
    int idle_pct = 9;      // 0 during the stretch without gaps
    bit hold_off = 1'b0;   // long receiver stall
    int quiet_cycles = 0;
    int steps_sent = 0;
    int stats_sent = 0;

    grid_diffusion_decay_stencil u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver side
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            grid_sb.check_result(out_data);
        out_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("grid_diffusion_decay_stencil regression: fail");
            $finish;
        end
    end

    // the block is never ready in the cycle after a transfer, so the
    // extra edge after dropping valid costs nothing
    task automatic send_cmd(logic [2:0] cmd, logic [5:0] r, logic [5:0] c,
                            logic [31:0] wv);
        in_item_t it;
        it.command = cmd;
        it.row = r;
        it.col = c;
        it.write_value = wv;
        while ($urandom_range(99) < idle_pct) @(posedge clk);
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        grid_sb.note_command(it);
        if (cmd == CMD_STEP) steps_sent++;
        if (cmd == CMD_STATS) stats_sent++;
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (grid_sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        grid_sb.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_cmd();
        int pick;
        logic [5:0] r, c;
        pick = $urandom_range(99);
        r = 6'($urandom);
        c = 6'($urandom);
        if (pick < 35) send_cmd(CMD_WRITE, r, c, ($urandom_range(3) == 0) ? $urandom
                                                 : $urandom_range(65535));
        else if (pick < 55) send_cmd(CMD_READ, r, c, $urandom);
        else if (pick < 75) send_cmd(CMD_PROD, r, c, $urandom);
        else if (pick < 84) send_cmd(CMD_STEP, r, c, $urandom);
        else if (pick < 94) send_cmd(CMD_STATS, r, c, $urandom);
        else send_cmd(3'($urandom_range(5, 7)), r, c, $urandom);
    endtask

    initial
    begin
        grid_sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corners, extremes, saturation, every command
        send_cmd(CMD_STATS, 6'd0, 6'd0, 32'd0);
        send_cmd(CMD_WRITE, 6'd0, 6'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_PROD, 6'd0, 6'd0, 32'd0);
        send_cmd(CMD_WRITE, 6'd63, 6'd63, 32'h0001_0000);
        send_cmd(CMD_WRITE, 6'd0, 6'd63, 32'h5555_AAAA);
        send_cmd(CMD_WRITE, 6'd63, 6'd0, 32'hAAAA_5555);
        send_cmd(CMD_WRITE, 6'd32, 6'd32, 32'h0000_0100);
        send_cmd(CMD_PROD, 6'd32, 6'd32, 32'd0);
        send_cmd(CMD_READ, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_cmd(3'd5, 6'd0, 6'd0, 32'd0);
        send_cmd(3'd7, 6'd63, 6'd0, 32'd0);
        send_cmd(CMD_STATS, 6'd1, 6'd1, 32'd0);
        send_cmd(CMD_STEP, 6'd0, 6'd0, 32'd0);
        send_cmd(CMD_STATS, 6'd0, 6'd0, 32'd0);
        drain();

        // extremes of every register, central-circle mode
        write_reg(CFG_DIFFUSION, 32'd16384);
        write_reg(CFG_DECAY, 32'hFFFF);
        write_reg(CFG_MODE, 32'd1);
        write_reg(CFG_SCALE, 32'd15);
        write_reg(CFG_PRODUCE, 32'hFFFF_FFFF);
        send_cmd(CMD_PROD, 6'd10, 6'd10, 32'd0);
        send_cmd(CMD_WRITE, 6'd30, 6'd31, 32'h0100_0000);
        send_cmd(CMD_STEP, 6'd0, 6'd0, 32'd0);
        send_cmd(CMD_STATS, 6'd0, 6'd0, 32'd0);
        drain();
        write_reg(CFG_DIFFUSION, 32'hFFFF_FFFF);
        write_reg(CFG_DECAY, 32'd0);
        write_reg(CFG_SCALE, 32'd0);
        write_reg(CFG_PRODUCE, 32'd0);
        send_cmd(CMD_STEP, 6'd0, 6'd0, 32'd0);
        send_cmd(CMD_PROD, 6'd30, 6'd31, 32'd0);
        drain();

        // random phases under several settings
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_DIFFUSION, $urandom_range(16384));
            write_reg(CFG_DECAY, (ph == 3) ? 32'hFFFF : $urandom_range(4000));
            write_reg(CFG_MODE, 32'(ph[0]));
            write_reg(CFG_SCALE, $urandom_range(1, 15));
            write_reg(CFG_PRODUCE, (ph == 2) ? 32'hFFFF_FFFF : $urandom_range(1 << 20));
            idle_pct = (ph == 1) ? 0 : 9;
            for (int n = 0; n < 30; n++) random_cmd();
            if (ph == 2)
            begin
                // receiver stalls long while sender keeps offering
                hold_off = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    for (int n = 0; n < 6; n++)
                        send_cmd(($urandom_range(1) != 0) ? CMD_READ : CMD_WRITE,
                                 6'($urandom), 6'($urandom), $urandom);
                join
            end
            drain();
        end
        idle_pct = 9;

        while (grid_sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("checked %0d results, %0d diffusion steps and %0d statistics sweeps",
                 grid_sb.checked, steps_sent, stats_sent);
        $display("covered register extremes, both loss modes, saturation and stalls");
        if (grid_sb.errors == 0 && grid_sb.pending.size() == 0)
            $display("grid_diffusion_decay_stencil regression: pass");
        else
            $display("grid_diffusion_decay_stencil regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
